// ----- sv/sasi_disk_controller_phases_defines.svh -----
// assertion macros for the sasi target phase controller
`ifndef SASI_DISK_CONTROLLER_PHASES_DEFINES_SVH
`define SASI_DISK_CONTROLLER_PHASES_DEFINES_SVH

// same-cycle implication, quiet while reset is high
`define SDCP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sdcp check failed");

// next-cycle implication, quiet while reset is high
`define SDCP_ASSERT_SEQ(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sdcp check failed");

`endif

// ----- sv/sdcp_pkg.sv -----
// shared types, codes and constants of the sasi target phase controller
package sdcp_pkg;

  localparam int CMD_BUFFER_BYTES_DEF = 10;
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;

  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_TICK  = 2'd2;

  localparam logic [1:0] OFS_DATA   = 2'd0;
  localparam logic [1:0] OFS_SELECT = 2'd1;
  localparam logic [1:0] OFS_UNUSED = 2'd2;
  localparam logic [1:0] OFS_SELREQ = 2'd3;

  localparam logic [2:0] REG_REQ_DELAY     = 3'd0;
  localparam logic [2:0] REG_SEL_REQ_DELAY = 3'd1;
  localparam logic [2:0] REG_REZERO_OP     = 3'd2;
  localparam logic [2:0] REG_SENSE_OP      = 3'd3;
  localparam logic [2:0] REG_SPECIFY_OP    = 3'd4;
  localparam logic [2:0] REG_SPECIFY_LEN   = 3'd5;
  localparam logic [2:0] REG_BLOCK_LEN     = 3'd6;

  localparam logic [4:0] SB_MSG = 5'h10;
  localparam logic [4:0] SB_CD  = 5'h08;
  localparam logic [4:0] SB_IO  = 5'h04;
  localparam logic [4:0] SB_BSY = 5'h02;
  localparam logic [4:0] SB_REQ = 5'h01;

  localparam logic [7:0]  CHECK_STATUS    = 8'h02;
  localparam logic [7:0]  UNUSED_READ     = 8'hff;
  localparam logic [3:0]  CMD_LEN_CLASS0  = 4'd6;
  localparam logic [3:0]  CMD_LEN_CLASS1  = 4'd10;
  localparam logic [3:0]  CMD_LEN_CLASS2  = 4'd8;
  localparam logic [11:0] SENSE_LEN_DEF   = 12'd4;
  localparam logic [11:0] SENSE_BYTES_NUM = 12'd4;

  localparam logic [7:0] SENSE_BYTES [4] = '{8'h01, 8'h00, 8'h00, 8'h00};

  typedef struct packed {
    logic [15:0] req_delay_ticks;
    logic [15:0] select_req_delay_ticks;
    logic [7:0]  rezero_opcode;
    logic [7:0]  sense_opcode;
    logic [7:0]  specify_opcode;
    logic [11:0] specify_length;
    logic [11:0] block_length;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    req_delay_ticks:        16'd45,
    select_req_delay_ticks: 16'd5,
    rezero_opcode:          8'h01,
    sense_opcode:           8'h03,
    specify_opcode:         8'hc2,
    specify_length:         12'd10,
    block_length:           12'h800
  };

endpackage

// ----- sv/sdcp_item_if.sv -----
// input channel: register access or tick
interface sdcp_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [1:0] reg_offset;
  logic [7:0] write_byte;

  modport source (output valid, action, reg_offset, write_byte, input ready);
  modport sink (input valid, action, reg_offset, write_byte, output ready);
endinterface

// ----- sv/sdcp_result_if.sv -----
// output channel: one read byte per access
interface sdcp_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_byte;

  modport source (output valid, read_byte, input ready);
  modport sink (input valid, read_byte, output ready);
endinterface

// ----- sv/sasi_disk_controller_phases.sv -----
// top level of the sasi target phase controller
//
//  channel  dir  signals                                   transfer when
//  in_ch    in   action, reg_offset, write_byte            valid && ready
//  out_ch   out  read_byte                                 valid && ready
//  apb      in   psel penable pwrite paddr pwdata prdata   psel && penable && pwrite
//
//  one transfer per cycle when out_ch is not stalled; results pass both registers to out_ch
//  the phase update is combinational, between the input register and the output register
//  rst clears phase, status, counters, countdown and both register valids
//  a stalled out_ch holds its byte; in_ch keeps taking transfers while the input register
//  can move on, so it stalls only when both registers are full
module sasi_disk_controller_phases
  import sdcp_pkg::*;
#(
  parameter int CMD_BUFFER_BYTES = CMD_BUFFER_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  sdcp_item_if.sink             in_ch,
  sdcp_result_if.source         out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t       cfg;
  logic       s1_valid;
  logic [1:0] s1_action;
  logic [1:0] s1_offset;
  logic [7:0] s1_byte;
  logic       out_valid;
  logic [7:0] out_byte;
  logic       exec;
  logic       take;
  logic [7:0] result;

  assign exec         = s1_valid && (!out_valid || out_ch.ready);
  assign in_ch.ready  = !s1_valid || exec;
  assign take         = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid;
  assign out_ch.read_byte = out_byte;

  sdcp_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sdcp_core #(
    .CMD_BUFFER_BYTES (CMD_BUFFER_BYTES)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .exec       (exec),
    .action     (s1_action),
    .reg_offset (s1_offset),
    .write_byte (s1_byte),
    .read_byte  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        s1_valid <= 1'b1;
      end else if (exec) begin
        s1_valid <= 1'b0;
      end
      if (exec) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_action <= in_ch.action;
      s1_offset <= in_ch.reg_offset;
      s1_byte   <= in_ch.write_byte;
    end
    if (exec) begin
      out_byte <= result;
    end
  end

endmodule

// ----- sv/sdcp_apb_regs.sv -----
// apb configuration registers
module sdcp_apb_regs
  import sdcp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  logic [2:0] idx;
  logic       wr;

  assign idx    = paddr[4:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (wr) begin
      case (idx)
        REG_REQ_DELAY:     cfg.req_delay_ticks        <= pwdata[15:0];
        REG_SEL_REQ_DELAY: cfg.select_req_delay_ticks <= pwdata[15:0];
        REG_REZERO_OP:     cfg.rezero_opcode          <= pwdata[7:0];
        REG_SENSE_OP:      cfg.sense_opcode           <= pwdata[7:0];
        REG_SPECIFY_OP:    cfg.specify_opcode         <= pwdata[7:0];
        REG_SPECIFY_LEN:   cfg.specify_length         <= pwdata[11:0];
        REG_BLOCK_LEN:     cfg.block_length           <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_REQ_DELAY:     prdata = {16'd0, cfg.req_delay_ticks};
      REG_SEL_REQ_DELAY: prdata = {16'd0, cfg.select_req_delay_ticks};
      REG_REZERO_OP:     prdata = {24'd0, cfg.rezero_opcode};
      REG_SENSE_OP:      prdata = {24'd0, cfg.sense_opcode};
      REG_SPECIFY_OP:    prdata = {24'd0, cfg.specify_opcode};
      REG_SPECIFY_LEN:   prdata = {20'd0, cfg.specify_length};
      REG_BLOCK_LEN:     prdata = {20'd0, cfg.block_length};
      default:           prdata = '0;
    endcase
  end

endmodule

// ----- sv/sdcp_core.sv -----
// bus phase state, command buffer, req countdown and per-access update
module sdcp_core
  import sdcp_pkg::*;
#(
  parameter int CMD_BUFFER_BYTES = CMD_BUFFER_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       exec,
  input  logic [1:0] action,
  input  logic [1:0] reg_offset,
  input  logic [7:0] write_byte,
  output logic [7:0] read_byte
);

  localparam int IDX_W = $clog2(CMD_BUFFER_BYTES);

  typedef enum logic [2:0] {
    PH_FREE, PH_SELECT, PH_COMMAND, PH_DATA_IN, PH_DATA_OUT, PH_STATUS, PH_MESSAGE
  } phase_t;

  phase_t      phase, phase_next;
  logic [4:0]  sbits, sbits_next;
  logic [7:0]  code, code_next;
  logic [3:0]  ccount, ccount_next;
  logic [3:0]  ctotal, ctotal_next;
  logic [11:0] xcount, xcount_next;
  logic [11:0] xtotal, xtotal_next;
  logic [15:0] cdown, cdown_next;
  logic        armed, armed_next;
  logic        store_we;
  logic [7:0]  cmd_store [CMD_BUFFER_BYTES];
  logic [7:0]  op;
  logic        is_sense;
  logic [11:0] tot;
  logic [3:0]  ctot;
  logic [15:0] dec;

  assign op       = cmd_store[0];
  assign is_sense = (op == cfg.sense_opcode);

  always_comb begin
    phase_next  = phase;
    sbits_next  = sbits;
    code_next   = code;
    ccount_next = ccount;
    ctotal_next = ctotal;
    xcount_next = xcount;
    xtotal_next = xtotal;
    cdown_next  = cdown;
    armed_next  = armed;
    store_we    = 1'b0;
    read_byte   = '0;
    tot         = xtotal;
    ctot        = ctotal;
    dec         = cdown;
    case (action)
      ACT_WRITE: begin
        case (reg_offset)
          OFS_DATA: begin
            if (phase == PH_DATA_OUT) begin
              if (xcount == '0) begin
                tot = (op == cfg.specify_opcode) ? cfg.specify_length : cfg.block_length;
              end
              xtotal_next = tot;
              sbits_next  = sbits & ~SB_REQ;
              cdown_next  = cfg.req_delay_ticks;
              armed_next  = 1'b1;
              xcount_next = xcount + 12'd1;
              if (xcount_next >= tot) begin
                phase_next = PH_STATUS;
                sbits_next = sbits_next | SB_IO | SB_CD;
              end
            end else if (phase == PH_COMMAND) begin
              if (ccount == '0) begin
                case (write_byte[7:5])
                  3'd1:    ctot = CMD_LEN_CLASS1;
                  3'd2:    ctot = CMD_LEN_CLASS2;
                  default: ctot = CMD_LEN_CLASS0;
                endcase
              end
              ctotal_next = ctot;
              store_we    = ({1'b0, ccount} < 5'(CMD_BUFFER_BYTES));
              sbits_next  = sbits & ~SB_REQ;
              cdown_next  = cfg.req_delay_ticks;
              armed_next  = 1'b1;
              ccount_next = ccount + 4'd1;
              if (ccount_next >= ctot) begin
                if (op == cfg.rezero_opcode) begin
                  phase_next = PH_STATUS;
                  sbits_next = sbits_next | SB_IO;
                end else if (is_sense) begin
                  phase_next  = PH_DATA_IN;
                  sbits_next  = (sbits_next | SB_IO) & ~SB_CD;
                  xcount_next = '0;
                  xtotal_next = '0;
                end else if (op == cfg.specify_opcode) begin
                  phase_next  = PH_DATA_OUT;
                  sbits_next  = sbits_next & ~(SB_IO | SB_CD);
                  xcount_next = '0;
                  xtotal_next = '0;
                end else begin
                  phase_next = PH_STATUS;
                  sbits_next = sbits_next | SB_IO;
                  code_next  = CHECK_STATUS;
                end
              end
            end
          end
          OFS_SELECT: begin
            if (write_byte == '0 && phase == PH_SELECT) begin
              phase_next  = PH_COMMAND;
              sbits_next  = sbits | SB_CD;
              ccount_next = '0;
              ctotal_next = '0;
              cdown_next  = cfg.select_req_delay_ticks;
              armed_next  = 1'b1;
            end
          end
          OFS_SELREQ: begin
            if (write_byte != '0 && phase == PH_FREE) begin
              phase_next = PH_SELECT;
              sbits_next = sbits | SB_BSY;
            end
          end
          default: ;
        endcase
      end
      ACT_READ: begin
        case (reg_offset)
          OFS_DATA: begin
            if (phase == PH_MESSAGE) begin
              phase_next = PH_FREE;
              sbits_next = '0;
              code_next  = '0;
            end else if (phase == PH_STATUS) begin
              phase_next = PH_MESSAGE;
              sbits_next = (sbits | SB_MSG) & ~SB_REQ;
              cdown_next = cfg.req_delay_ticks;
              armed_next = 1'b1;
              read_byte  = code;
            end else if (phase == PH_DATA_IN) begin
              if (xcount == '0) begin
                if (is_sense) begin
                  tot = (cmd_store[3] == '0) ? SENSE_LEN_DEF : {4'd0, cmd_store[3]};
                end else begin
                  tot = '0;
                end
              end
              xtotal_next = tot;
              if (is_sense && xcount < SENSE_BYTES_NUM) begin
                read_byte = SENSE_BYTES[xcount[1:0]];
              end
              sbits_next  = sbits & ~SB_REQ;
              cdown_next  = cfg.req_delay_ticks;
              armed_next  = 1'b1;
              xcount_next = xcount + 12'd1;
              if (xcount_next >= tot) begin
                phase_next = PH_STATUS;
                sbits_next = sbits_next | SB_IO | SB_CD;
              end
            end
          end
          OFS_SELECT: read_byte = {3'd0, sbits};
          default:    read_byte = UNUSED_READ;
        endcase
      end
      ACT_TICK: begin
        if (armed) begin
          dec        = (cdown != '0) ? cdown - 16'd1 : cdown;
          cdown_next = dec;
          if (dec == '0) begin
            sbits_next = sbits | SB_REQ;
            armed_next = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_FREE;
      sbits  <= '0;
      code   <= '0;
      ccount <= '0;
      ctotal <= '0;
      xcount <= '0;
      xtotal <= '0;
      cdown  <= '0;
      armed  <= 1'b0;
    end else if (exec) begin
      phase  <= phase_next;
      sbits  <= sbits_next;
      code   <= code_next;
      ccount <= ccount_next;
      ctotal <= ctotal_next;
      xcount <= xcount_next;
      xtotal <= xtotal_next;
      cdown  <= cdown_next;
      armed  <= armed_next;
    end
  end

  always_ff @(posedge clk) begin
    if (exec && store_we) begin
      cmd_store[ccount[IDX_W-1:0]] <= write_byte;
    end
  end

endmodule

// ----- sv/sdcp_checker.sv -----
// port-level checks of the sasi target phase controller
`include "sasi_disk_controller_phases_defines.svh"

module sdcp_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_read_byte
);

  // output is empty right after reset
  `SDCP_ASSERT_IMP(a_out_empty_after_rst, $past(rst), !out_valid)

  // input backs up only when the output side is full and stalled
  `SDCP_ASSERT_IMP(a_in_stall_needs_full_out, !in_ready, out_valid && !out_ready)

  // a stalled result keeps its byte
  `SDCP_ASSERT_SEQ(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_read_byte))

  // no transfer at the first edge after reset keeps the output empty while nothing can reach it
  `SDCP_ASSERT_SEQ(a_no_early_result, $past(rst) && !(in_valid && in_ready),
    !out_valid ##1 !out_valid)

endmodule

bind sasi_disk_controller_phases sdcp_checker u_sdcp_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_read_byte (out_ch.read_byte)
);

// ----- test/sasi_disk_controller_phases_tb.sv -----
// testbench for the sasi target phase controller: phase sequences, countdowns, register settings
module sasi_disk_controller_phases_tb;
  import sdcp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam logic [1:0] ACT_UNDEFINED = 2'd3;

  typedef enum logic [2:0] {
    BUS_FREE, BUS_SELECT, BUS_COMMAND, BUS_DATA_IN, BUS_DATA_OUT, BUS_STATUS, BUS_MESSAGE
  } bus_phase_e;

  logic clk = 1'b0;
  logic rst;
  logic psel, penable, pwrite, pready;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata, prdata;

  sdcp_item_if in_ch ();
  sdcp_result_if out_ch ();

  sasi_disk_controller_phases dut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // shadow of the target state
  cfg_t        cfg_shadow = CFG_RESET;
  bus_phase_e  bus_phase = BUS_FREE;
  logic [4:0]  stat_bits = '0;
  logic [7:0]  stat_code = '0;
  logic [7:0]  cmd_bytes [CMD_BUFFER_BYTES_DEF] = '{default: 8'h00};
  logic [3:0]  cmd_count = '0;
  logic [3:0]  cmd_total = '0;
  logic [11:0] xfer_count = '0;
  logic [11:0] xfer_total = '0;
  logic [15:0] req_timer = '0;
  logic        req_running = 1'b0;

  logic [7:0]  pending_read_bytes [$];
  logic [7:0]  cmd_plan [CMD_BUFFER_BYTES_DEF];

  int  accesses_sent = 0;
  int  bytes_checked = 0;
  int  mismatch_count = 0;
  int  cycle_count = 0;
  int  n_rezero = 0, n_sense = 0, n_specify = 0, n_check = 0;
  bit  send_gaps = 1'b1;
  bit  recv_gaps = 1'b1;
  int  hold_off_len = 0;

  function automatic void arm_req_timer(input logic [15:0] ticks);
    req_timer = ticks;
    req_running = 1'b1;
  endfunction

  function automatic void drop_req();
    stat_bits &= ~SB_REQ;
    arm_req_timer(cfg_shadow.req_delay_ticks);
  endfunction

  function automatic void decode_command();
    logic [7:0] op;
    op = cmd_bytes[0];
    if (op == cfg_shadow.rezero_opcode) begin
      bus_phase = BUS_STATUS;
      stat_bits |= SB_IO;
      n_rezero++;
    end else if (op == cfg_shadow.sense_opcode) begin
      bus_phase = BUS_DATA_IN;
      stat_bits |= SB_IO;
      stat_bits &= ~SB_CD;
      xfer_count = '0;
      xfer_total = '0;
      n_sense++;
    end else if (op == cfg_shadow.specify_opcode) begin
      bus_phase = BUS_DATA_OUT;
      stat_bits &= ~(SB_IO | SB_CD);
      xfer_count = '0;
      xfer_total = '0;
      n_specify++;
    end else begin
      bus_phase = BUS_STATUS;
      stat_bits |= SB_IO;
      stat_code = CHECK_STATUS;
      n_check++;
    end
  endfunction

  function automatic void data_write(input logic [7:0] b);
    logic [2:0] cls;
    if (bus_phase == BUS_DATA_OUT) begin
      if (xfer_count == 0)
        xfer_total = (cmd_bytes[0] == cfg_shadow.specify_opcode) ?
                     cfg_shadow.specify_length : cfg_shadow.block_length;
      drop_req();
      xfer_count = xfer_count + 12'd1;
      if (xfer_count >= xfer_total) begin
        bus_phase = BUS_STATUS;
        stat_bits |= SB_IO | SB_CD;
      end
    end else if (bus_phase == BUS_COMMAND) begin
      if (cmd_count == 0) begin
        cls = b[7:5];
        cmd_total = (cls == 3'd1) ? CMD_LEN_CLASS1 :
                    (cls == 3'd2) ? CMD_LEN_CLASS2 : CMD_LEN_CLASS0;
      end
      if (cmd_count < CMD_BUFFER_BYTES_DEF)
        cmd_bytes[cmd_count] = b;
      drop_req();
      cmd_count = cmd_count + 4'd1;
      if (cmd_count >= cmd_total)
        decode_command();
    end
  endfunction

  function automatic logic [7:0] data_read();
    logic [7:0] value;
    logic       is_sense;
    value = 8'h00;
    if (bus_phase == BUS_MESSAGE) begin
      bus_phase = BUS_FREE;
      stat_bits = '0;
      stat_code = '0;
      return 8'h00;
    end
    if (bus_phase == BUS_STATUS) begin
      bus_phase = BUS_MESSAGE;
      stat_bits |= SB_MSG;
      drop_req();
      return stat_code;
    end
    if (bus_phase != BUS_DATA_IN)
      return 8'h00;
    is_sense = (cmd_bytes[0] == cfg_shadow.sense_opcode);
    if (xfer_count == 0) begin
      if (is_sense)
        xfer_total = (cmd_bytes[3] == 8'h00) ? SENSE_LEN_DEF : {4'd0, cmd_bytes[3]};
      else
        xfer_total = '0;
    end
    if (is_sense && xfer_count < SENSE_BYTES_NUM)
      value = SENSE_BYTES[xfer_count[1:0]];
    drop_req();
    xfer_count = xfer_count + 12'd1;
    if (xfer_count >= xfer_total) begin
      bus_phase = BUS_STATUS;
      stat_bits |= SB_IO | SB_CD;
    end
    return value;
  endfunction

  function automatic logic [7:0] advance_bus(input logic [1:0] act, input logic [1:0] ofs,
                                             input logic [7:0] wb);
    logic [7:0] rd;
    rd = 8'h00;
    case (act)
      ACT_WRITE: begin
        case (ofs)
          OFS_DATA: data_write(wb);
          OFS_SELECT: begin
            if (wb == 8'h00 && bus_phase == BUS_SELECT) begin
              bus_phase = BUS_COMMAND;
              stat_bits |= SB_CD;
              cmd_count = '0;
              cmd_total = '0;
              arm_req_timer(cfg_shadow.select_req_delay_ticks);
            end
          end
          OFS_SELREQ: begin
            if (wb != 8'h00 && bus_phase == BUS_FREE) begin
              bus_phase = BUS_SELECT;
              stat_bits |= SB_BSY;
            end
          end
          default: ;
        endcase
      end
      ACT_READ: begin
        if (ofs == OFS_DATA)
          rd = data_read();
        else if (ofs == OFS_SELECT)
          rd = {3'b000, stat_bits};
        else
          rd = UNUSED_READ;
      end
      ACT_TICK: begin
        if (req_running) begin
          if (req_timer != 0)
            req_timer = req_timer - 16'd1;
          if (req_timer == 0) begin
            stat_bits |= SB_REQ;
            req_running = 1'b0;
          end
        end
      end
      default: ;
    endcase
    return rd;
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("mismatch at cycle %0d: %s, got %02h expected %02h", cycle_count, what, got, want);
    mismatch_count++;
  endtask

  task automatic send_access(input logic [1:0] act, input logic [1:0] ofs,
                             input logic [7:0] wb);
    @(negedge clk);
    if (send_gaps && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.action <= act;
    in_ch.reg_offset <= ofs;
    in_ch.write_byte <= wb;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    pending_read_bytes.push_back(advance_bus(act, ofs, wb));
    accesses_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_read_bytes.size() != 0) @(posedge clk);
  endtask

  task automatic apb_write(input logic [2:0] idx, input logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    case (idx)
      REG_REQ_DELAY:     cfg_shadow.req_delay_ticks = value[15:0];
      REG_SEL_REQ_DELAY: cfg_shadow.select_req_delay_ticks = value[15:0];
      REG_REZERO_OP:     cfg_shadow.rezero_opcode = value[7:0];
      REG_SENSE_OP:      cfg_shadow.sense_opcode = value[7:0];
      REG_SPECIFY_OP:    cfg_shadow.specify_opcode = value[7:0];
      REG_SPECIFY_LEN:   cfg_shadow.specify_length = value[11:0];
      REG_BLOCK_LEN:     cfg_shadow.block_length = value[11:0];
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic write_register(input logic [2:0] idx, input logic [31:0] value);
    wait_drained();
    apb_write(idx, value);
  endtask

  task automatic apply_config(input logic [15:0] req_d, input logic [15:0] sel_d,
                              input logic [7:0] rz, input logic [7:0] sn, input logic [7:0] sp,
                              input logic [11:0] sp_len, input logic [11:0] blk_len);
    write_register(REG_REQ_DELAY, {16'd0, req_d});
    write_register(REG_SEL_REQ_DELAY, {16'd0, sel_d});
    write_register(REG_REZERO_OP, {24'd0, rz});
    write_register(REG_SENSE_OP, {24'd0, sn});
    write_register(REG_SPECIFY_OP, {24'd0, sp});
    write_register(REG_SPECIFY_LEN, {20'd0, sp_len});
    write_register(REG_BLOCK_LEN, {20'd0, blk_len});
  endtask

  task automatic send_noise();
    case ($urandom_range(0, 7))
      0, 1, 2, 3: send_access(ACT_TICK, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      4: send_access(ACT_READ, OFS_SELECT, 8'($urandom_range(0, 255)));
      5: send_access(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                     8'($urandom_range(0, 255)));
      6: send_access(2'($urandom_range(0, 1)), $urandom_range(0, 1) ? OFS_UNUSED : OFS_SELREQ,
                     8'($urandom_range(0, 255)));
      default: send_access(ACT_UNDEFINED, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
    endcase
  endtask

  task automatic drive_phases(input int noise_pct, input bit stop_after_command);
    int steps;
    steps = 0;
    while (bus_phase != BUS_FREE && steps < 10000) begin
      if (stop_after_command && bus_phase != BUS_SELECT && bus_phase != BUS_COMMAND)
        break;
      steps++;
      if ($urandom_range(0, 99) < noise_pct)
        send_noise();
      else begin
        case (bus_phase)
          BUS_SELECT:   send_access(ACT_WRITE, OFS_SELECT, 8'h00);
          BUS_COMMAND:  send_access(ACT_WRITE, OFS_DATA, cmd_plan[cmd_count]);
          BUS_DATA_OUT: send_access(ACT_WRITE, OFS_DATA, 8'($urandom_range(0, 255)));
          default:      send_access(ACT_READ, OFS_DATA, 8'($urandom_range(0, 255)));
        endcase
      end
    end
  endtask

  task automatic run_command(input logic [7:0] opcode, input logic [7:0] length_byte,
                             input int noise_pct, input bit stop_after_command);
    for (int i = 0; i < CMD_BUFFER_BYTES_DEF; i++)
      cmd_plan[i] = 8'($urandom_range(0, 255));
    cmd_plan[0] = opcode;
    cmd_plan[3] = length_byte;
    send_access(ACT_WRITE, OFS_SELREQ, 8'($urandom_range(1, 255)));
    send_access(ACT_WRITE, OFS_SELECT, 8'h00);
    drive_phases(noise_pct, stop_after_command);
  endtask

  function automatic logic [7:0] pick_opcode(input int kind);
    logic [7:0] op;
    case (kind)
      0: op = cfg_shadow.rezero_opcode;
      1: op = cfg_shadow.sense_opcode;
      2: op = cfg_shadow.specify_opcode;
      default: begin
        do op = 8'($urandom_range(0, 255));
        while (op == cfg_shadow.rezero_opcode || op == cfg_shadow.sense_opcode ||
               op == cfg_shadow.specify_opcode);
      end
    endcase
    return op;
  endfunction

  task automatic test_idle_accesses();
    send_access(ACT_READ, OFS_DATA, 8'h00);
    send_access(ACT_READ, OFS_SELECT, 8'hff);
    send_access(ACT_READ, OFS_UNUSED, 8'h55);
    send_access(ACT_READ, OFS_SELREQ, 8'haa);
    send_access(ACT_WRITE, OFS_DATA, 8'hff);
    send_access(ACT_WRITE, OFS_SELECT, 8'h00);
    send_access(ACT_WRITE, OFS_UNUSED, 8'hff);
    send_access(ACT_WRITE, OFS_SELREQ, 8'h00);
    send_access(ACT_TICK, OFS_DATA, 8'h00);
    send_access(ACT_UNDEFINED, OFS_SELREQ, 8'hff);
    send_access(ACT_READ, OFS_SELECT, 8'h00);
  endtask

  task automatic test_rezero();
    run_command(cfg_shadow.rezero_opcode, 8'h00, 30, 1'b0);
  endtask

  task automatic test_sense();
    run_command(cfg_shadow.sense_opcode, 8'h00, 20, 1'b0);
    run_command(cfg_shadow.sense_opcode, 8'h07, 20, 1'b0);
  endtask

  task automatic test_specify();
    run_command(cfg_shadow.specify_opcode, 8'h00, 20, 1'b0);
  endtask

  task automatic test_check_status();
    run_command(8'h3f, 8'h00, 20, 1'b0);
    run_command(8'h5a, 8'h00, 20, 1'b0);
    run_command(8'he0, 8'h00, 20, 1'b0);
  endtask

  task automatic test_equal_opcodes();
    write_register(REG_REZERO_OP, 32'h40);
    write_register(REG_SENSE_OP, 32'h40);
    write_register(REG_SPECIFY_OP, 32'h40);
    run_command(8'h40, 8'h02, 20, 1'b0);
    write_register(REG_REZERO_OP, {24'd0, CFG_RESET.rezero_opcode});
    run_command(8'h40, 8'h02, 20, 1'b0);
    write_register(REG_SENSE_OP, {24'd0, CFG_RESET.sense_opcode});
    write_register(REG_SPECIFY_OP, {24'd0, CFG_RESET.specify_opcode});
  endtask

  task automatic test_block_length_path();
    write_register(REG_SPECIFY_LEN, 32'd5);
    write_register(REG_BLOCK_LEN, 32'd1);
    run_command(cfg_shadow.specify_opcode, 8'h00, 0, 1'b1);
    write_register(REG_SPECIFY_OP, 32'h77);
    drive_phases(20, 1'b0);
    write_register(REG_BLOCK_LEN, 32'd3);
    run_command(cfg_shadow.specify_opcode, 8'h00, 0, 1'b1);
    write_register(REG_SPECIFY_OP, {24'd0, CFG_RESET.specify_opcode});
    drive_phases(20, 1'b0);
  endtask

  task automatic test_countdown();
    write_register(REG_REQ_DELAY, 32'd0);
    write_register(REG_SEL_REQ_DELAY, 32'd0);
    run_command(cfg_shadow.rezero_opcode, 8'h00, 40, 1'b0);
    write_register(REG_REQ_DELAY, 32'd3);
    write_register(REG_SEL_REQ_DELAY, 32'd1);
    run_command(cfg_shadow.rezero_opcode, 8'h00, 0, 1'b0);
    repeat (4) begin
      send_access(ACT_TICK, OFS_DATA, 8'h00);
      send_access(ACT_READ, OFS_SELECT, 8'h00);
    end
    write_register(REG_REQ_DELAY, 32'd65535);
    write_register(REG_SEL_REQ_DELAY, 32'd65535);
    run_command(cfg_shadow.sense_opcode, 8'h02, 40, 1'b0);
    write_register(REG_REQ_DELAY, 32'd4);
    write_register(REG_SEL_REQ_DELAY, 32'd2);
  endtask

  task automatic test_zero_length();
    write_register(REG_SPECIFY_LEN, 32'd0);
    run_command(cfg_shadow.specify_opcode, 8'h00, 20, 1'b0);
    write_register(REG_SPECIFY_LEN, 32'd1);
    run_command(cfg_shadow.specify_opcode, 8'h00, 20, 1'b0);
  endtask

  task automatic test_opcode_extremes();
    write_register(REG_REZERO_OP, 32'h00);
    write_register(REG_SENSE_OP, 32'h2a);
    write_register(REG_SPECIFY_OP, 32'hff);
    run_command(8'h00, 8'h00, 20, 1'b0);
    run_command(8'h2a, 8'h05, 20, 1'b0);
    run_command(8'hff, 8'h00, 20, 1'b0);
    write_register(REG_REZERO_OP, 32'hff);
    write_register(REG_SENSE_OP, 32'h4b);
    write_register(REG_SPECIFY_OP, 32'h00);
    run_command(8'hff, 8'h00, 20, 1'b0);
    run_command(8'h4b, 8'h01, 20, 1'b0);
    run_command(8'h00, 8'h00, 20, 1'b0);
  endtask

  task automatic test_long_transfer();
    write_register(REG_SPECIFY_LEN, 32'd160);
    write_register(REG_BLOCK_LEN, 32'd4095);
    send_gaps = 1'b0;
    recv_gaps = 1'b0;
    run_command(cfg_shadow.specify_opcode, 8'h00, 0, 1'b0);
    send_gaps = 1'b1;
    recv_gaps = 1'b1;
    write_register(REG_SPECIFY_LEN, 32'd10);
  endtask

  task automatic test_backpressure();
    wait_drained();
    @(posedge clk);
    send_gaps = 1'b0;
    hold_off_len = 150;
    repeat (16) begin
      send_access(ACT_TICK, OFS_DATA, 8'h00);
      send_access(ACT_READ, OFS_SELECT, 8'h00);
    end
    send_gaps = 1'b1;
    wait_drained();
  endtask

  task automatic test_random();
    int start;
    logic [7:0] rz, sn, sp;
    for (int chunk = 0; chunk < 4; chunk++) begin
      if ($urandom_range(0, 4) == 0) begin
        rz = CFG_RESET.rezero_opcode;
        sn = CFG_RESET.sense_opcode;
        sp = CFG_RESET.specify_opcode;
      end else begin
        rz = 8'($urandom_range(0, 255));
        sn = 8'($urandom_range(0, 255));
        sp = 8'($urandom_range(0, 255));
      end
      apply_config(16'($urandom_range(1, 12)), 16'($urandom_range(1, 12)), rz, sn, sp,
                   12'($urandom_range(1, 12)), 12'($urandom_range(1, 4095)));
      send_gaps = (chunk != 3);
      recv_gaps = (chunk != 3);
      start = accesses_sent;
      while (accesses_sent - start < 70) begin
        if ($urandom_range(0, 99) < 85)
          run_command(pick_opcode($urandom_range(0, 3)),
                      ($urandom_range(0, 39) == 0) ? 8'($urandom_range(0, 255)) :
                                                     8'($urandom_range(0, 9)),
                      $urandom_range(0, 40), 1'b0);
        else
          repeat ($urandom_range(1, 5)) send_noise();
      end
    end
  endtask

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_len != 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold_off_len) @(negedge clk);
        hold_off_len = 0;
        out_ch.ready <= 1'b1;
      end else if (recv_gaps && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(negedge clk);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_results
    logic [7:0] want;
    if (!rst && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_read_bytes.size() == 0) begin
        report_mismatch("transfer with nothing expected", out_ch.read_byte, 8'h00);
      end else begin
        want = pending_read_bytes.pop_front();
        if (out_ch.read_byte !== want)
          report_mismatch("read_byte", out_ch.read_byte, want);
      end
      bytes_checked++;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d bytes still expected", cycle_count,
               pending_read_bytes.size());
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.action = ACT_TICK;
    in_ch.reg_offset = OFS_DATA;
    in_ch.write_byte = 8'h00;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_idle_accesses();
    test_rezero();
    test_sense();
    test_specify();
    test_check_status();
    test_equal_opcodes();
    test_block_length_path();
    test_countdown();
    test_zero_length();
    test_opcode_extremes();
    test_long_transfer();
    test_backpressure();
    test_random();
    wait_drained();
    repeat (10) @(posedge clk);
    $display("%0d accesses driven, %0d read bytes checked, %0d mismatches",
             accesses_sent, bytes_checked, mismatch_count);
    $display("commands decoded: %0d rezero, %0d request sense, %0d specify, %0d check status",
             n_rezero, n_sense, n_specify, n_check);
    if (mismatch_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
